### design/ipbb_pkg.sv
// Package for the incremental PID / bang-bang motor drive loop.
// Holds field widths, register indexes, reset values and the result struct.
// No dependencies.
package ipbb_pkg;

    localparam int IN_W     = 16;   // setpoint, measured
    localparam int ERR_W    = 17;   // setpoint - measured
    localparam int GAIN_W   = 16;   // Q8.8 gains
    localparam int BAND_W   = 16;
    localparam int STEP_W   = 15;
    localparam int LIM_W    = 15;
    localparam int DRV_W    = 16;
    localparam int DUTY_W   = 15;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W    = 38;   // exact PID accumulator
    localparam int BANG_W   = 36;   // exact bang-bang sum

    localparam int S_TDATA_W = 2 * IN_W;
    localparam int M_TDATA_W = DRV_W + 2 * DUTY_W + MODE_W;

    // 0.82 in Q0.16
    localparam logic [15:0] K_DECAY = 16'd53740;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BANG_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd5;

    // reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P     = 16'd1766;
    localparam logic [GAIN_W-1:0] RST_GAIN_I     = 16'd607;
    localparam logic [GAIN_W-1:0] RST_GAIN_D     = 16'd563;
    localparam logic [BAND_W-1:0] RST_ERROR_BAND = 16'd1300;
    localparam logic [STEP_W-1:0] RST_BANG_STEP  = 15'd1620;
    localparam logic [LIM_W-1:0]  RST_OUT_LIMIT  = 15'd9000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PID = 2'd0,
        MODE_FWD = 2'd1,
        MODE_REV = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [DUTY_W-1:0]        reverse_duty;
        logic [DUTY_W-1:0]        forward_duty;
        logic signed [DRV_W-1:0]  drive_out;
    } t_result;

endpackage

### design/ipbb_core.sv
// Next drive value for one control tick: PID increment or bang-bang step,
// truncation toward zero, clamp and duty split.
// Depends on ipbb_pkg.
module ipbb_core (
    input  logic signed [ipbb_pkg::ERR_W-1:0]  i_err,
    input  ipbb_pkg::t_mode                    i_mode,
    input  logic signed [ipbb_pkg::DRV_W-1:0]  i_last,
    input  logic signed [ipbb_pkg::ERR_W-1:0]  i_err1,
    input  logic signed [ipbb_pkg::ERR_W-1:0]  i_err2,
    input  logic [ipbb_pkg::GAIN_W-1:0]        i_gain_p,
    input  logic [ipbb_pkg::GAIN_W-1:0]        i_gain_i,
    input  logic [ipbb_pkg::GAIN_W-1:0]        i_gain_d,
    input  logic [ipbb_pkg::STEP_W-1:0]        i_bang_step,
    input  logic [ipbb_pkg::LIM_W-1:0]         i_out_limit,
    output ipbb_pkg::t_result                  o_result
);

    localparam int AW = ipbb_pkg::ACC_W;
    localparam int BW = ipbb_pkg::BANG_W;

    logic signed [ipbb_pkg::ERR_W:0]   d1;
    logic signed [ipbb_pkg::ERR_W+1:0] d2;
    logic signed [AW-1:0] prod_p, prod_i, prod_d, acc, acc_adj, pid_q;
    logic signed [BW-1:0] bang_prod, step_term, bang_sum, bang_adj, bang_q;
    logic signed [AW-1:0] drv, lim_w;
    logic signed [ipbb_pkg::DRV_W-1:0] drive;
    logic signed [ipbb_pkg::DRV_W-1:0] drive_neg;

    assign d1 = {i_err[ipbb_pkg::ERR_W-1], i_err} - {i_err1[ipbb_pkg::ERR_W-1], i_err1};
    assign d2 = {{2{i_err[ipbb_pkg::ERR_W-1]}}, i_err}
              - {i_err1[ipbb_pkg::ERR_W-1], i_err1, 1'b0}
              + {{2{i_err2[ipbb_pkg::ERR_W-1]}}, i_err2};

    // three gain products side by side, all exact at accumulator width
    assign prod_p = AW'($signed({1'b0, i_gain_p})) * AW'(d1);
    assign prod_i = AW'($signed({1'b0, i_gain_i})) * AW'(i_err);
    assign prod_d = AW'($signed({1'b0, i_gain_d})) * AW'(d2);
    assign acc    = prod_p + prod_i + prod_d
                  + {{(AW-ipbb_pkg::DRV_W-8){i_last[ipbb_pkg::DRV_W-1]}}, i_last, 8'd0};
    // bias negatives so the arithmetic shift truncates toward zero
    assign acc_adj = acc + (acc[AW-1] ? AW'(255) : AW'(0));
    assign pid_q   = acc_adj >>> 8;

    assign bang_prod = BW'($signed({1'b0, ipbb_pkg::K_DECAY})) * BW'(i_last);
    assign step_term = {{(BW-ipbb_pkg::STEP_W-16){1'b0}}, i_bang_step, 16'd0};
    assign bang_sum  = (i_mode == ipbb_pkg::MODE_REV) ? bang_prod - step_term
                                                      : bang_prod + step_term;
    assign bang_adj  = bang_sum + (bang_sum[BW-1] ? BW'(65535) : BW'(0));
    assign bang_q    = bang_adj >>> 16;

    assign lim_w = {{(AW-ipbb_pkg::LIM_W){1'b0}}, i_out_limit};

    always_comb begin
        case (i_mode) inside
            ipbb_pkg::MODE_FWD,
            ipbb_pkg::MODE_REV: drv = {{(AW-BW){bang_q[BW-1]}}, bang_q};
            default:            drv = pid_q;
        endcase
        if (drv > lim_w) begin
            drv = lim_w;
        end else if (drv < -lim_w) begin
            drv = -lim_w;
        end
        drive     = drv[ipbb_pkg::DRV_W-1:0];
        drive_neg = -drive;
    end

    assign o_result.mode         = i_mode;
    assign o_result.drive_out    = drive;
    assign o_result.forward_duty = drive[ipbb_pkg::DRV_W-1] ? '0
                                                            : drive[ipbb_pkg::DUTY_W-1:0];
    assign o_result.reverse_duty = drive[ipbb_pkg::DRV_W-1] ? drive_neg[ipbb_pkg::DUTY_W-1:0]
                                                            : '0;

endmodule

### design/incremental_pid_bang_bang_motor_drive_top.sv
// Top level of the incremental PID / bang-bang motor speed loop.
// Uses ipbb_pkg and ipbb_core.
//
// Usage:
//   Slave stream carries one control tick per transaction: setpoint and
//   measured speed. Master stream returns one transaction per tick: the
//   clamped drive, forward and reverse PWM duty and the loop mode taken.
//   Configuration registers (gains, error band, bang step, output limit)
//   are written through i_cfg_we / i_cfg_idx / i_cfg_data while the block
//   is idle; writes to indexes beyond the register list are ignored.
//   A tick accepted into the input stage moves on to the result register and
//   from there appears on m_tvalid. Throughput: one tick per cycle while m_tready
//   holds; the stored drive and error history loop closes combinationally in ipbb_core.
//   When the receiver stalls, the result register holds, the input stage
//   fills, and s_tready drops once both are occupied; nothing is lost.
//   Reset (synchronous, active low) empties the pipeline, clears the drive
//   and error history and loads the default register values.
module incremental_pid_bang_bang_motor_drive_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // setpoint [15:0], measured [31:16]
    input  logic [ipbb_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // drive_out [15:0], forward_duty [30:16], reverse_duty [45:31], loop_mode [47:46]
    output logic [ipbb_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  i_cfg_we,
    input  logic [ipbb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ipbb_pkg::CFG_W-1:0]            i_cfg_data
);

    logic [ipbb_pkg::GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [ipbb_pkg::BAND_W-1:0] r_error_band;
    logic [ipbb_pkg::STEP_W-1:0] r_bang_step;
    logic [ipbb_pkg::LIM_W-1:0]  r_out_limit;

    logic                                r_s1_valid;
    logic signed [ipbb_pkg::ERR_W-1:0]   r_s1_err;
    ipbb_pkg::t_mode                     r_s1_mode;

    logic                                r_m_valid;
    ipbb_pkg::t_result                   r_result;

    logic signed [ipbb_pkg::DRV_W-1:0]   r_last;
    logic signed [ipbb_pkg::ERR_W-1:0]   r_err1, r_err2;

    logic signed [ipbb_pkg::IN_W-1:0]    setpoint, measured;
    logic signed [ipbb_pkg::ERR_W-1:0]   n_err;
    logic signed [ipbb_pkg::ERR_W:0]     band_pos, err_ext;
    ipbb_pkg::t_mode                     n_mode;
    ipbb_pkg::t_result                   n_result;
    logic                                out_free, s1_move, s_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= ipbb_pkg::RST_GAIN_P;
            r_gain_i     <= ipbb_pkg::RST_GAIN_I;
            r_gain_d     <= ipbb_pkg::RST_GAIN_D;
            r_error_band <= ipbb_pkg::RST_ERROR_BAND;
            r_bang_step  <= ipbb_pkg::RST_BANG_STEP;
            r_out_limit  <= ipbb_pkg::RST_OUT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ipbb_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                ipbb_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                ipbb_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                ipbb_pkg::REG_ERROR_BAND: r_error_band <= i_cfg_data;
                ipbb_pkg::REG_BANG_STEP:  r_bang_step  <= i_cfg_data[ipbb_pkg::STEP_W-1:0];
                ipbb_pkg::REG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[ipbb_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: result register frees when taken, input stage drains into it
    assign out_free = !r_m_valid || m_tready;
    assign s1_move  = r_s1_valid && out_free;
    assign s_tready = !r_s1_valid || out_free;
    assign s_accept = s_tvalid && s_tready;

    // error and mode selection on the way into the input stage
    assign setpoint = s_tdata[ipbb_pkg::IN_W-1:0];
    assign measured = s_tdata[2*ipbb_pkg::IN_W-1:ipbb_pkg::IN_W];
    assign n_err    = {setpoint[ipbb_pkg::IN_W-1], setpoint}
                    - {measured[ipbb_pkg::IN_W-1], measured};
    assign band_pos = {2'b00, r_error_band};
    assign err_ext  = {n_err[ipbb_pkg::ERR_W-1], n_err};

    always_comb begin
        if (err_ext > band_pos) begin
            n_mode = ipbb_pkg::MODE_FWD;
        end else if (err_ext < -band_pos) begin
            n_mode = ipbb_pkg::MODE_REV;
        end else begin
            n_mode = ipbb_pkg::MODE_PID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_err  <= n_err;
            r_s1_mode <= n_mode;
        end
    end

    ipbb_core u_core (
        .i_err       (r_s1_err),
        .i_mode      (r_s1_mode),
        .i_last      (r_last),
        .i_err1      (r_err1),
        .i_err2      (r_err2),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_bang_step (r_bang_step),
        .i_out_limit (r_out_limit),
        .o_result    (n_result)
    );

    // loop state: advance once per transaction leaving the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_err1 <= '0;
            r_err2 <= '0;
        end else if (s1_move) begin
            r_last <= n_result.drive_out;
            if (r_s1_mode == ipbb_pkg::MODE_PID) begin
                r_err2 <= r_err1;
                r_err1 <= r_s1_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_result <= n_result;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_result;

endmodule

### tb/sv/ipbb_drive_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the motor drive loop: follows register writes, predicts the
// result of every accepted tick and compares it with the master stream. Uses ipbb_pkg.
module ipbb_drive_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // setpoint [15:0], measured [31:16]
    input  logic [ipbb_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // drive_out [15:0], forward_duty [30:16], reverse_duty [45:31], loop_mode [47:46]
    input  logic [ipbb_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_we,
    input  logic [ipbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipbb_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic [ipbb_pkg::GAIN_W-1:0]       gain_p, gain_i, gain_d;
    logic [ipbb_pkg::BAND_W-1:0]       error_band;
    logic [ipbb_pkg::STEP_W-1:0]       bang_step;
    logic [ipbb_pkg::LIM_W-1:0]        out_limit;
    logic signed [ipbb_pkg::DRV_W-1:0] stored_drive;
    logic signed [ipbb_pkg::ERR_W-1:0] err_hist1, err_older;
    ipbb_pkg::t_result                 pending_drives[$];

    function automatic longint trunc_to_zero(input longint v, input int sh);
        return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
    endfunction

    // One control tick: update the stored drive and error history, return the result.
    function automatic ipbb_pkg::t_result advance_drive_loop(
        input logic signed [ipbb_pkg::IN_W-1:0] sp,
        input logic signed [ipbb_pkg::IN_W-1:0] ms);
        longint            e;
        longint            acc;
        longint            lim;
        longint            drv;
        ipbb_pkg::t_result r;
        e   = longint'(sp) - longint'(ms);
        lim = longint'(out_limit);
        if (e > longint'(error_band)) begin
            r.mode = ipbb_pkg::MODE_FWD;
            drv = trunc_to_zero(longint'(ipbb_pkg::K_DECAY) * longint'(stored_drive)
                                + longint'(bang_step) * 65536, 16);
        end else if (e < -longint'(error_band)) begin
            r.mode = ipbb_pkg::MODE_REV;
            drv = trunc_to_zero(longint'(ipbb_pkg::K_DECAY) * longint'(stored_drive)
                                - longint'(bang_step) * 65536, 16);
        end else begin
            acc = longint'(gain_p) * (e - longint'(err_hist1))
                + longint'(gain_i) * e
                + longint'(gain_d) * (e - 2 * longint'(err_hist1) + longint'(err_older));
            r.mode = ipbb_pkg::MODE_PID;
            drv = trunc_to_zero(longint'(stored_drive) * 256 + acc, 8);
            err_older = err_hist1;
            err_hist1 = ipbb_pkg::ERR_W'(e);
        end
        if (drv > lim) drv = lim;
        if (drv < -lim) drv = -lim;
        stored_drive   = ipbb_pkg::DRV_W'(drv);
        r.drive_out    = stored_drive;
        r.forward_duty = (drv >= 0) ? ipbb_pkg::DUTY_W'(drv) : '0;
        r.reverse_duty = (drv < 0) ? ipbb_pkg::DUTY_W'(-drv) : '0;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%s", what);
    endfunction

    always @(posedge i_clk) begin
        ipbb_pkg::t_result got;
        ipbb_pkg::t_result want;
        if (!i_rst_n) begin
            gain_p       = ipbb_pkg::RST_GAIN_P;
            gain_i       = ipbb_pkg::RST_GAIN_I;
            gain_d       = ipbb_pkg::RST_GAIN_D;
            error_band   = ipbb_pkg::RST_ERROR_BAND;
            bang_step    = ipbb_pkg::RST_BANG_STEP;
            out_limit    = ipbb_pkg::RST_OUT_LIMIT;
            stored_drive = '0;
            err_hist1    = '0;
            err_older    = '0;
            o_fail_count = 0;
            pending_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ipbb_pkg::REG_GAIN_P:     gain_p     = i_cfg_data;
                    ipbb_pkg::REG_GAIN_I:     gain_i     = i_cfg_data;
                    ipbb_pkg::REG_GAIN_D:     gain_d     = i_cfg_data;
                    ipbb_pkg::REG_ERROR_BAND: error_band = i_cfg_data;
                    ipbb_pkg::REG_BANG_STEP:  bang_step  = i_cfg_data[ipbb_pkg::STEP_W-1:0];
                    ipbb_pkg::REG_OUT_LIMIT:  out_limit  = i_cfg_data[ipbb_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            // Check the output side first: a tick accepted at this edge cannot leave yet.
            if (i_m_tvalid && i_m_tready) begin
                got = ipbb_pkg::t_result'(i_m_tdata);
                if (pending_drives.size() == 0) begin
                    note_failure($sformatf({"unexpected drive transaction: drive %0d",
                                            " fwd %0d rev %0d mode %0d"},
                                           got.drive_out, got.forward_duty,
                                           got.reverse_duty, got.mode));
                end else begin
                    want = pending_drives.pop_front();
                    if (got.drive_out !== want.drive_out
                        || got.forward_duty !== want.forward_duty
                        || got.reverse_duty !== want.reverse_duty
                        || got.mode !== want.mode)
                        note_failure($sformatf({"drive mismatch: expected drive %0d fwd %0d",
                                                " rev %0d mode %0d, got drive %0d fwd %0d",
                                                " rev %0d mode %0d"},
                                               want.drive_out, want.forward_duty,
                                               want.reverse_duty, want.mode,
                                               got.drive_out, got.forward_duty,
                                               got.reverse_duty, got.mode));
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_drives.push_back(advance_drive_loop(
                    i_s_tdata[ipbb_pkg::IN_W-1:0],
                    i_s_tdata[2*ipbb_pkg::IN_W-1:ipbb_pkg::IN_W]));
        end
        o_pending = pending_drives.size();
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the motor drive loop testbench: clock, reset, tick and register stimulus
// with random idling, and the verdict. Uses ipbb_pkg, ipbb_drive_checker and the block.
module tb_top;

    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 106;
    localparam logic [ipbb_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [ipbb_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic [ipbb_pkg::S_TDATA_W-1:0] s_tdata    = '0;
    logic                           s_tvalid   = 1'b0;
    logic                           s_tready;
    logic [ipbb_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tvalid;
    logic                           m_tready   = 1'b1;
    logic                           i_cfg_we   = 1'b0;
    logic [ipbb_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [ipbb_pkg::CFG_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_band       = int'(ipbb_pkg::RST_ERROR_BAND);
    int quiet_cycles   = 0;

    incremental_pid_bang_bang_motor_drive_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ipbb_drive_checker drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // All tasks start and end just after a falling edge.
    task automatic send_tick(input int sp, input int ms);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tdata  = {ipbb_pkg::IN_W'(ms), ipbb_pkg::IN_W'(sp)};
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ipbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipbb_pkg::CFG_W-1:0]     val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        if (idx == ipbb_pkg::REG_ERROR_BAND) cur_band = int'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [ipbb_pkg::CFG_W-1:0] pick_reg(input int bits, input int typical);
        case ($urandom_range(9)) inside
            0:       return '0;
            1:       return ipbb_pkg::CFG_W'((1 << bits) - 1);
            2, 3:    return ipbb_pkg::CFG_W'($urandom_range((1 << bits) - 1));
            default: return ipbb_pkg::CFG_W'($urandom_range(typical));
        endcase
    endfunction

    initial begin
        int e;
        int b;
        int lo;
        int hi;
        int sp;
        int ms;
        int kind;
        int corner[4];
        corner = '{-32768, 32767, 0, -1};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default registers: errors on and just past both band edges, then field extremes.
        send_tick(0, 0);
        send_tick(1300, 0);
        send_tick(0, 1300);
        send_tick(1301, 0);
        send_tick(0, 1301);
        send_tick(32767, -32768);
        send_tick(-32768, 32767);
        send_tick(32767, 32767);
        send_tick(-32768, -32768);
        // drive the loop into both ends of the clamp
        repeat (4) send_tick(1300, 0);
        repeat (3) send_tick(-1300, 0);

        wait_idle();
        write_reg(ipbb_pkg::REG_GAIN_P, '1);
        write_reg(ipbb_pkg::REG_GAIN_I, '1);
        write_reg(ipbb_pkg::REG_GAIN_D, '1);
        write_reg(ipbb_pkg::REG_ERROR_BAND, '1);
        write_reg(ipbb_pkg::REG_BANG_STEP, ipbb_pkg::CFG_W'(15'h7FFF));
        write_reg(ipbb_pkg::REG_OUT_LIMIT, ipbb_pkg::CFG_W'(15'h7FFF));
        // unused indexes must not disturb any register
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, '1);
        send_tick(32767, -32768);
        send_tick(-32768, 32767);
        send_tick(0, 0);

        wait_idle();
        write_reg(ipbb_pkg::REG_GAIN_P, '0);
        write_reg(ipbb_pkg::REG_GAIN_I, '0);
        write_reg(ipbb_pkg::REG_GAIN_D, '0);
        write_reg(ipbb_pkg::REG_ERROR_BAND, '0);
        send_tick(1, 0);
        send_tick(0, 1);
        send_tick(0, 0);

        wait_idle();
        write_reg(ipbb_pkg::REG_BANG_STEP, '0);
        write_reg(ipbb_pkg::REG_OUT_LIMIT, '0);
        send_tick(5000, 0);
        send_tick(0, 0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            write_reg(ipbb_pkg::REG_GAIN_P, pick_reg(ipbb_pkg::GAIN_W, 2048));
            write_reg(ipbb_pkg::REG_GAIN_I, pick_reg(ipbb_pkg::GAIN_W, 2048));
            write_reg(ipbb_pkg::REG_GAIN_D, pick_reg(ipbb_pkg::GAIN_W, 2048));
            write_reg(ipbb_pkg::REG_ERROR_BAND, pick_reg(ipbb_pkg::BAND_W, 3000));
            write_reg(ipbb_pkg::REG_BANG_STEP, pick_reg(ipbb_pkg::STEP_W, 4000));
            write_reg(ipbb_pkg::REG_OUT_LIMIT, pick_reg(ipbb_pkg::LIM_W, 12000));
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          ipbb_pkg::CFG_W'($urandom));
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase

            repeat (TICKS_PER_PHASE) begin
                kind = $urandom_range(19);
                if (kind < 4) begin
                    sp = $urandom;
                    ms = $urandom;
                end else if (kind < 6) begin
                    sp = corner[$urandom_range(3)];
                    ms = corner[$urandom_range(3)];
                end else begin
                    // mostly errors around the band so the PID history keeps moving
                    b = (cur_band > 65534) ? 65534 : cur_band;
                    e = int'($urandom_range(2 * b + 2)) - (b + 1);
                    case (kind)
                        6:       e = cur_band;
                        7:       e = -cur_band;
                        8:       e = ($urandom_range(1) != 0) ? cur_band + 1 : -cur_band - 1;
                        default: ;
                    endcase
                    if (e > 65535) e = 65535;
                    if (e < -65535) e = -65535;
                    lo = (e > 0) ? -32768 : -32768 - e;
                    hi = (e > 0) ? 32767 - e : 32767;
                    ms = lo + int'($urandom_range(hi - lo));
                    sp = ms + e;
                end
                send_tick(sp, ms);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### files.f
design/ipbb_pkg.sv
design/ipbb_core.sv
design/incremental_pid_bang_bang_motor_drive_top.sv
tb/sv/ipbb_drive_checker.sv
tb/sv/tb_top.sv
